// File: hdl/wdm_pkg.sv
`timescale 1ns / 1ps
package wdm_pkg;
  localparam int MaxWords   = 1024;
  localparam int MaxLetters = 16;
  localparam int IdxW  = $clog2(MaxWords);
  localparam int CntW  = $clog2(MaxWords + 1);
  localparam int PosW  = $clog2(MaxLetters);
  localparam int LenW  = $clog2(MaxLetters + 2);
  localparam int CodeW = 5;
  localparam int RowW  = CodeW * MaxLetters;
  localparam int AddrW = IdxW;

  localparam logic [CodeW-1:0] CodeBad  = 5'd30;
  localparam logic [CodeW-1:0] CodeWild = 5'd31;
  localparam logic [7:0] CharStar = 8'h2A;
  localparam logic [7:0] CharA    = 8'h41;

  typedef enum logic [1:0] {
    KIND_WORD  = 2'd0,
    KIND_PAT   = 2'd1,
    KIND_MATCH = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_TAKEN   = 4'd0,
    ST_STORED  = 4'd1,
    ST_INVALID = 4'd2,
    ST_DUP     = 4'd3,
    ST_LONG    = 4'd4,
    ST_FULL    = 4'd5,
    ST_PREADY  = 4'd6,
    ST_MATCH   = 4'd7,
    ST_NONE    = 4'd8,
    ST_READ    = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_RDWAIT, S_SCAN, S_SCANWAIT, S_OUT
  } state_e;

  // Compare mode handed along the cell row
  typedef struct packed {
    logic dup;      // exact compare against assembled word
  } cmp_mode_t;

  function automatic logic [CodeW-1:0] fold_char(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) return CodeW'(c - 8'h61);
    if (c >= 8'h41 && c <= 8'h5A) return CodeW'(c - 8'h41);
    if (c == CharStar) return CodeWild;
    return CodeBad;
  endfunction
endpackage

// File: hdl/wdm_if.sv
`timescale 1ns / 1ps
interface wdm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] character;
  logic       last;
  logic       enforce_length;
  logic [9:0] word_index;
  logic [3:0] position;
  modport source (output valid, kind, character, last, enforce_length, word_index, position,
                  input ready);
  modport sink   (input valid, kind, character, last, enforce_length, word_index, position,
                  output ready);
endinterface

interface wdm_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [9:0]  match_index;
  logic [4:0]  match_length;
  logic [7:0]  read_char;
  logic [10:0] word_count;
  modport source (output valid, status, match_index, match_length, read_char, word_count,
                  input ready);
  modport sink   (input valid, status, match_index, match_length, read_char, word_count,
                  output ready);
endinterface

// File: hdl/wdm_ram.sv
`timescale 1ns / 1ps
module wdm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: hdl/wdm_cell.sv
`timescale 1ns / 1ps
// One letter position: compares its letter and passes an and-chain result on
module wdm_cell import wdm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [CodeW-1:0] ref_i,     // assembled letter or pattern letter
  input  logic             active_i,  // position lies within compare length
  input  cmp_mode_t        mode_i,
  input  logic [CodeW-1:0] stored_i,
  input  logic             ok_i,
  output logic             ok_o
);
  logic [CodeW-1:0] ref_q;
  logic             act_q;
  logic             hit;

  // Hold the reference letter for this position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (load_i) begin
      act_q <= active_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (load_i) ref_q <= ref_i;
  end

  always_comb begin
    if (!act_q) hit = 1'b1;
    else if (!mode_i.dup && ref_q == CodeWild) hit = 1'b1;
    else hit = (ref_q == stored_i);
  end
  assign ok_o = ok_i & hit;
endmodule

// File: hdl/wildcard_dictionary_matcher_core.sv
`timescale 1ns / 1ps
// Channel | Dir | Payload
// in_if   | in  | kind, character, last, enforce_length, word_index, position
// out_if  | out | status, match_index, match_length, read_char, word_count
// Plain character words go from the accept state S_IDLE straight to the result state S_OUT.
// A finishing dictionary word (store not empty) or a match request with a ready pattern visits
// stored rows one at a time, each row through S_SCANWAIT (RAM read) then S_SCAN (compare),
// stopping at the first hit; a duplicate check starts at row 0 and a match at the cursor.
// Reads pass through S_RDWAIT to S_OUT. Reset is asynchronous; stores are not cleared.
// A stalled result holds the block in S_OUT; input is taken only in S_IDLE.
module wildcard_dictionary_matcher_core import wdm_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  wdm_in_if.sink   in_if,
  wdm_out_if.source out_if
);
  state_e state_q, state_d;
  logic [CntW-1:0]  count_q;
  logic [CodeW-1:0] asm_q [MaxLetters];
  logic [LenW-1:0]  asm_len_q;
  logic             asm_bad_q;
  logic [CodeW-1:0] pat_q [MaxLetters];
  logic [LenW-1:0]  pat_len_q;
  logic             p_ready_q, p_enf_q, p_void_q;
  logic [CntW-1:0]  cur_q;      // row under compare
  logic [CntW-1:0]  scan_q;     // match cursor, kept across requests
  logic             dup_q;      // scan is a duplicate check
  logic [PosW-1:0]  rpos_q;
  logic             rhit_q;
  logic [3:0]       st_q;
  logic [IdxW-1:0]  midx_q;
  logic [4:0]       mlen_q;
  logic [7:0]       rch_q;

  logic             acc;
  logic [CodeW-1:0] code;
  assign acc  = in_if.valid && in_if.ready;
  assign code = fold_char(in_if.character);
  assign in_if.ready = (state_q == S_IDLE);

  // Next assembly and pattern values for the word being accepted
  logic [LenW-1:0] plen_base, alen_n, plen_n, wlen_n, pl_n;
  logic            pvoid_base, wbad_n, wok_n, pv_n;
  assign plen_base  = p_ready_q ? '0 : pat_len_q;
  assign pvoid_base = p_ready_q ? 1'b0 : p_void_q;
  assign alen_n = (asm_len_q <= LenW'(MaxLetters)) ? asm_len_q + 1'b1 : asm_len_q;
  assign plen_n = (plen_base <= LenW'(MaxLetters)) ? plen_base + 1'b1 : plen_base;
  assign wbad_n = asm_bad_q | (code >= CodeBad);
  assign wlen_n = (code >= CodeBad) ? asm_len_q : alen_n;
  assign wok_n  = !wbad_n && (wlen_n <= LenW'(MaxLetters));
  assign pv_n   = pvoid_base | (code == CodeBad);
  assign pl_n   = (code == CodeBad) ? plen_base : plen_n;

  // Valid word finishing with non-empty store starts a duplicate scan
  logic fin_scan;
  assign fin_scan = in_if.last && wok_n && (count_q != '0);

  // Empty store write: row comes from the assembly registers
  logic we_first;
  assign we_first = (state_q == S_OUT) && (st_q == ST_STORED) && !dup_q && (count_q == '0);

  // Stores
  logic             we;
  logic [IdxW-1:0]  raddr;
  logic [RowW-1:0]  row_w, row_r;
  logic [LenW-1:0]  len_r;
  logic [IdxW-1:0]  cur_idx;
  assign cur_idx = cur_q[IdxW-1:0];
  always_comb begin
    for (int i = 0; i < MaxLetters; i++) row_w[i*CodeW +: CodeW] = asm_q[i];
  end
  wdm_ram #(.Width(RowW), .Depth(MaxWords)) u_letters (
    .clk_i, .we_i(we), .waddr_i(count_q[IdxW-1:0]), .wdata_i(row_w),
    .raddr_i(raddr), .rdata_o(row_r));
  wdm_ram #(.Width(LenW), .Depth(MaxWords)) u_lengths (
    .clk_i, .we_i(we), .waddr_i(count_q[IdxW-1:0]), .wdata_i(asm_len_q),
    .raddr_i(raddr), .rdata_o(len_r));

  // Cell row: load references while the row is read
  logic      load;
  cmp_mode_t mode;
  logic [MaxLetters:0] ok;
  logic [LenW-1:0] cmp_len;
  assign load = (state_q == S_SCANWAIT);
  assign cmp_len = dup_q ? asm_len_q : pat_len_q;
  assign mode.dup = dup_q;
  assign ok[0] = 1'b1;
  for (genvar g = 0; g < MaxLetters; g++) begin : g_cell
    wdm_cell u_cell (
      .clk_i, .rst_ni, .load_i(load),
      .ref_i(dup_q ? asm_q[g] : pat_q[g]),
      .active_i(LenW'(g) < cmp_len),
      .mode_i(mode), .stored_i(row_r[g*CodeW +: CodeW]),
      .ok_i(ok[g]), .ok_o(ok[g+1]));
  end

  logic len_ok, hit;
  always_comb begin
    if (dup_q) len_ok = (len_r == asm_len_q);
    else if (p_enf_q) len_ok = (len_r == pat_len_q);
    else len_ok = (len_r >= pat_len_q);
    hit = len_ok && ok[MaxLetters] && (dup_q || !p_void_q);
  end

  // Read address: scan cursor or read index
  assign raddr = (state_q == S_IDLE) ? in_if.word_index[IdxW-1:0] : cur_idx;

  always_comb begin
    state_d = state_q;
    we = we_first;
    unique case (state_q)
      S_IDLE: if (acc) begin
        unique case (kind_e'(in_if.kind))
          KIND_READ:  state_d = S_RDWAIT;
          KIND_WORD:  state_d = fin_scan ? S_SCANWAIT : S_OUT;
          KIND_MATCH: begin
            if (p_ready_q && scan_q < count_q) state_d = S_SCANWAIT;
            else state_d = S_OUT;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_RDWAIT: state_d = S_OUT;
      S_SCANWAIT: state_d = S_SCAN;
      S_SCAN: begin
        if (hit) state_d = S_OUT;
        else if (cur_q + 1'b1 < count_q) state_d = S_SCANWAIT;
        else begin
          state_d = S_OUT;
          we = dup_q && (count_q < CntW'(MaxWords));
        end
      end
      S_OUT: if (out_if.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; asm_len_q <= '0; asm_bad_q <= 1'b0; pat_len_q <= '0;
      p_ready_q <= 1'b0; p_enf_q <= 1'b0; p_void_q <= 1'b0; cur_q <= '0;
      scan_q <= '0; dup_q <= 1'b0;
    end else begin
      if (acc) begin
        unique case (kind_e'(in_if.kind))
          KIND_WORD: begin
            if (in_if.last) begin
              asm_bad_q <= 1'b0;
              // Hold the length of a valid word until it is stored or refused
              if (wok_n) asm_len_q <= wlen_n;
              else asm_len_q <= '0;
              if (fin_scan) begin
                dup_q <= 1'b1; cur_q <= '0;
              end
            end else begin
              asm_len_q <= wlen_n; asm_bad_q <= wbad_n;
            end
          end
          KIND_PAT: begin
            pat_len_q <= pl_n;
            p_void_q  <= pv_n;
            p_ready_q <= 1'b0;
            p_enf_q   <= p_ready_q ? 1'b0 : p_enf_q;
            if (in_if.last) begin
              p_ready_q <= 1'b1;
              p_enf_q   <= in_if.enforce_length;
              p_void_q  <= pv_n | (pl_n > LenW'(MaxLetters));
              scan_q    <= '0;
            end
          end
          KIND_MATCH: begin
            dup_q <= 1'b0;
            cur_q <= scan_q;
          end
          default: ;
        endcase
      end
      if (state_q == S_SCAN) begin
        if (!dup_q) begin
          cur_q  <= cur_q + 1'b1;
          scan_q <= cur_q + 1'b1;
        end else if (hit || cur_q + 1'b1 >= count_q) begin
          if (!hit && count_q < CntW'(MaxWords)) count_q <= count_q + 1'b1;
          asm_len_q <= '0;
          dup_q <= 1'b0; cur_q <= '0;
        end else cur_q <= cur_q + 1'b1;
      end
      // Direct store when no duplicate scan is needed (store empty)
      if (we_first) begin
        count_q <= count_q + 1'b1; asm_len_q <= '0;
      end
    end
  end

  // Letters and results
  always_ff @(posedge clk_i) begin
    if (acc) begin
      unique case (kind_e'(in_if.kind))
        KIND_WORD: if (code < CodeBad && asm_len_q < LenW'(MaxLetters))
          asm_q[asm_len_q[PosW-1:0]] <= code;
        KIND_PAT: if (code != CodeBad && plen_base < LenW'(MaxLetters))
          pat_q[plen_base[PosW-1:0]] <= code;
        default: ;
      endcase
      rpos_q <= in_if.position[PosW-1:0];
      rhit_q <= ({1'b0, in_if.word_index} < count_q);
      midx_q <= '0; mlen_q <= '0; rch_q <= '0;
    end
    if (state_q == S_RDWAIT) begin
      st_q <= ST_READ;
      if (rhit_q && LenW'(rpos_q) < len_r)
        rch_q <= CharA + 8'(row_r[rpos_q*CodeW +: CodeW]);
    end
    if (state_q == S_SCAN) begin
      if (dup_q) begin
        if (hit) st_q <= ST_DUP;
        else if (cur_q + 1'b1 >= count_q)
          st_q <= (count_q < CntW'(MaxWords)) ? ST_STORED : ST_FULL;
      end else if (hit) begin
        st_q <= ST_MATCH; midx_q <= cur_idx; mlen_q <= 5'(len_r);
      end else if (cur_q + 1'b1 >= count_q) st_q <= ST_NONE;
    end
    if (acc) begin
      unique case (kind_e'(in_if.kind))
        KIND_WORD: begin
          if (!in_if.last) st_q <= ST_TAKEN;
          else if (wbad_n) st_q <= ST_INVALID;
          else if (wlen_n > LenW'(MaxLetters)) st_q <= ST_LONG;
          else st_q <= ST_STORED;
        end
        KIND_PAT: begin
          if (!in_if.last) st_q <= ST_TAKEN;
          else if (pv_n) st_q <= ST_INVALID;
          else if (pl_n > LenW'(MaxLetters)) st_q <= ST_LONG;
          else st_q <= ST_PREADY;
        end
        KIND_MATCH: st_q <= ST_NONE;
        default: st_q <= ST_READ;
      endcase
    end
  end

  assign out_if.valid        = (state_q == S_OUT);
  assign out_if.status       = st_q;
  assign out_if.match_index  = midx_q;
  assign out_if.match_length = mlen_q;
  assign out_if.read_char    = rch_q;
  assign out_if.word_count   = (we_first) ? count_q + 1'b1 : count_q;

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> state_q == S_IDLE) else $error("ready outside idle");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxWords)) else $error("count overflow");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> cur_q < count_q) else $error("scan past store");
endmodule
